FILE: rtl/core/tsmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the transport stream packet parser.
// No dependencies; tsmp_apb, tsmp_decode, tsmp_out_stage and the top level refer to this package.
package tsmp_pkg;

    localparam int unsigned PktLen = 188;
    localparam logic [7:0] PktLast = 8'(PktLen - 1);
    localparam logic [7:0] SyncByte = 8'h47;
    localparam logic [12:0] NullPid = 13'h1FFF;

    // Adaptation field and marked run layout.
    localparam logic [7:0] FieldEndNoAdapt = 8'd4;
    localparam logic [7:0] FieldEndAfZero = 8'd5;
    localparam logic [7:0] AfLenPos = 8'd4;
    localparam logic [7:0] StuffStartPos = 8'd6;
    localparam logic [7:0] StuffRunMinEnd = 8'd9;
    localparam logic [7:0] NullRunMaxStart = 8'(PktLen - 3);

    // Configuration port.
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;
    localparam logic RegMarkerIdx = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_DATA   = 4'b1000
    } t_run_phase;

    typedef struct packed {
        logic        marked_valid;
        logic        payload_valid;
        logic [7:0]  out_byte;
        logic        packet_end;
        logic [12:0] packet_pid;
        logic [3:0]  continuity;
        logic        has_adaptation;
        logic        has_payload_flag;
        logic        null_packet;
        logic [7:0]  stuffing_count;
        logic [7:0]  marked_length;
        logic        sync_error;
    } t_result;

    // Handover from the decoder to the result register.
    typedef struct packed {
        logic    load;
        t_result res;
    } t_result_bus;

endpackage

FILE: rtl/core/tsmp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the parser: the byte input and the result output.
// No dependencies.
interface tsmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface tsmp_out_if;
    logic        valid;
    logic        ready;
    logic        marked_valid;
    logic        payload_valid;
    logic [7:0]  out_byte;
    logic        packet_end;
    logic [12:0] packet_pid;
    logic [3:0]  continuity;
    logic        has_adaptation;
    logic        has_payload_flag;
    logic        null_packet;
    logic [7:0]  stuffing_count;
    logic [7:0]  marked_length;
    logic        sync_error;

    modport source (
        output valid, input ready,
        output marked_valid, output payload_valid, output out_byte, output packet_end,
        output packet_pid, output continuity, output has_adaptation,
        output has_payload_flag, output null_packet, output stuffing_count,
        output marked_length, output sync_error
    );
    modport sink (
        input valid, output ready,
        input marked_valid, input payload_valid, input out_byte, input packet_end,
        input packet_pid, input continuity, input has_adaptation,
        input has_payload_flag, input null_packet, input stuffing_count,
        input marked_length, input sync_error
    );
endinterface

FILE: rtl/core/tsmp_apb.sv
`timescale 1ns / 1ps
// APB-style configuration register file of the parser (marker byte register).
// Depends on tsmp_pkg.
module tsmp_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsmp_pkg::ApbAddrW-1:0]  paddr,
    input  logic [tsmp_pkg::ApbDataW-1:0]  pwdata,
    output logic [tsmp_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    output logic [7:0]                     o_marker
);

    logic [7:0] r_marker;
    logic       reg_idx;
    logic       wr_en;

    // Registers sit on 32-bit words; the low address bits are ignored.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= 8'd0;
        end else if (wr_en && reg_idx == tsmp_pkg::RegMarkerIdx) begin
            r_marker <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == tsmp_pkg::RegMarkerIdx) begin
            prdata = {{(tsmp_pkg::ApbDataW - 8){1'b0}}, r_marker};
        end
    end

    assign o_marker = r_marker;

endmodule

FILE: rtl/core/tsmp_decode.sv
`timescale 1ns / 1ps
// Input register and per-byte packet decoder: header fields, adaptation field,
// marked run tracking and payload selection. Depends on tsmp_pkg and tsmp_if.
module tsmp_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsmp_in_if.sink               i_in,
    input  logic [7:0]            i_marker,
    input  logic                  i_take,
    output tsmp_pkg::t_result_bus o_bus
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  advance;

    logic [7:0]            r_pos, n_pos;
    logic [12:0]           r_pid, n_pid;
    logic [3:0]            r_cc, n_cc;
    logic                  r_pay, n_pay;
    logic                  r_adapt, n_adapt;
    logic                  r_sync_err, n_sync_err;
    logic                  r_af_nz, n_af_nz;
    logic [7:0]            r_field_end, n_field_end;
    tsmp_pkg::t_run_phase  r_phase, n_phase;
    logic                  r_len_hi_nz, n_len_hi_nz;
    logic [7:0]            r_remaining, n_remaining;
    logic [7:0]            r_region_end, n_region_end;
    logic [7:0]            r_acc_len, n_acc_len;

    logic                  marked;
    logic                  payload;
    logic                  is_last;
    logic                  is_null;
    logic                  stuff_start;
    logic                  null_start;
    logic [7:0]            fe;
    logic [8:0]            af_end;
    logic [8:0]            run_end;
    logic [7:0]            rem_dec;
    tsmp_pkg::t_result     res;

    assign advance    = r_in_valid && i_take;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.stream_byte;
        end
    end

    assign is_last = (r_pos == tsmp_pkg::PktLast);
    assign is_null = (r_pid == tsmp_pkg::NullPid);
    assign af_end  = 9'd5 + {1'b0, r_in_byte};
    assign run_end = {1'b0, r_pos} + 9'd1 + {1'b0, r_in_byte};
    assign rem_dec = (r_remaining != 8'd0) ? r_remaining - 8'd1 : 8'd0;

    always_comb begin
        n_pid        = r_pid;
        n_cc         = r_cc;
        n_pay        = r_pay;
        n_adapt      = r_adapt;
        n_sync_err   = r_sync_err;
        n_af_nz      = r_af_nz;
        n_field_end  = r_field_end;
        n_phase      = r_phase;
        n_len_hi_nz  = r_len_hi_nz;
        n_remaining  = r_remaining;
        n_region_end = r_region_end;
        n_acc_len    = r_acc_len;
        marked       = 1'b0;
        payload      = 1'b0;
        stuff_start  = 1'b0;
        null_start   = 1'b0;
        fe           = r_field_end;

        if (r_pos == 8'd0) begin
            n_pid        = '0;
            n_cc         = '0;
            n_pay        = 1'b0;
            n_adapt      = 1'b0;
            n_af_nz      = 1'b0;
            n_field_end  = '0;
            n_phase      = tsmp_pkg::PH_IDLE;
            n_len_hi_nz  = 1'b0;
            n_remaining  = '0;
            n_region_end = '0;
            n_acc_len    = '0;
            n_sync_err   = (r_in_byte != tsmp_pkg::SyncByte);
        end else if (!r_sync_err) begin
            if (r_pos == 8'd1) begin
                n_pid = {r_in_byte[4:0], 8'd0};
            end else if (r_pos == 8'd2) begin
                n_pid = {r_pid[12:8], r_in_byte};
            end else if (r_pos == 8'd3) begin
                n_cc    = r_in_byte[3:0];
                n_pay   = r_in_byte[4];
                n_adapt = r_in_byte[5];
                n_af_nz = 1'b0;
                if (!r_in_byte[5]) begin
                    n_field_end = tsmp_pkg::FieldEndNoAdapt;
                end
            end else begin
                // The adaptation length is clamped so the field never runs past the packet.
                if (r_pos == tsmp_pkg::AfLenPos && r_adapt) begin
                    if (r_in_byte != 8'd0) begin
                        fe      = (af_end > 9'(tsmp_pkg::PktLen)) ? 8'(tsmp_pkg::PktLen)
                                                                  : af_end[7:0];
                        n_af_nz = 1'b1;
                    end else begin
                        fe = tsmp_pkg::FieldEndAfZero;
                    end
                end
                n_field_end = fe;

                case (r_phase)
                    tsmp_pkg::PH_DATA: begin
                        marked      = 1'b1;
                        n_remaining = rem_dec;
                        if (rem_dec == 8'd0) begin
                            n_phase = tsmp_pkg::PH_IDLE;
                        end
                    end
                    tsmp_pkg::PH_LEN_LO: begin
                        // A length with a nonzero high byte can never fit in a packet.
                        if (!r_len_hi_nz && r_in_byte != 8'd0
                                && run_end <= {1'b0, r_region_end}) begin
                            n_remaining = r_in_byte;
                            n_acc_len   = r_in_byte;
                            n_phase     = tsmp_pkg::PH_DATA;
                        end else begin
                            n_phase = tsmp_pkg::PH_IDLE;
                        end
                    end
                    tsmp_pkg::PH_LEN_HI: begin
                        n_len_hi_nz = (r_in_byte != 8'd0);
                        n_phase     = tsmp_pkg::PH_LEN_LO;
                    end
                    default: begin
                        stuff_start = r_adapt && n_af_nz && r_pos == tsmp_pkg::StuffStartPos
                                      && fe >= tsmp_pkg::StuffRunMinEnd;
                        null_start  = is_null && r_pay && r_pos == fe
                                      && fe < tsmp_pkg::NullRunMaxStart;
                        n_phase     = tsmp_pkg::PH_IDLE;
                        if ((stuff_start || null_start) && r_in_byte == i_marker) begin
                            n_region_end = stuff_start ? fe : 8'(tsmp_pkg::PktLen);
                            n_phase      = tsmp_pkg::PH_LEN_HI;
                        end
                    end
                endcase

                payload = r_pay && !is_null && r_pos >= fe;
            end
        end

        n_pos = is_last ? 8'd0 : r_pos + 8'd1;
    end

    always_comb begin
        res               = '0;
        res.marked_valid  = marked;
        res.payload_valid = payload;
        res.out_byte      = r_in_byte;
        res.packet_end    = is_last;
        if (is_last) begin
            if (n_sync_err) begin
                res.sync_error = 1'b1;
            end else begin
                res.packet_pid       = n_pid;
                res.continuity       = n_cc;
                res.has_adaptation   = n_adapt;
                res.has_payload_flag = n_pay;
                res.null_packet      = (n_pid == tsmp_pkg::NullPid);
                res.marked_length    = n_acc_len;
                if (n_adapt && n_af_nz && n_field_end > tsmp_pkg::StuffStartPos) begin
                    res.stuffing_count = n_field_end - tsmp_pkg::StuffStartPos;
                end
            end
        end
    end

    assign o_bus.load = advance && (marked || payload || is_last);
    assign o_bus.res  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_pid        <= '0;
            r_cc         <= '0;
            r_pay        <= 1'b0;
            r_adapt      <= 1'b0;
            r_sync_err   <= 1'b0;
            r_af_nz      <= 1'b0;
            r_field_end  <= '0;
            r_phase      <= tsmp_pkg::PH_IDLE;
            r_len_hi_nz  <= 1'b0;
            r_remaining  <= '0;
            r_region_end <= '0;
            r_acc_len    <= '0;
        end else if (advance) begin
            r_pos        <= n_pos;
            r_pid        <= n_pid;
            r_cc         <= n_cc;
            r_pay        <= n_pay;
            r_adapt      <= n_adapt;
            r_sync_err   <= n_sync_err;
            r_af_nz      <= n_af_nz;
            r_field_end  <= n_field_end;
            r_phase      <= n_phase;
            r_len_hi_nz  <= n_len_hi_nz;
            r_remaining  <= n_remaining;
            r_region_end <= n_region_end;
            r_acc_len    <= n_acc_len;
        end
    end

    a_pos_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= tsmp_pkg::PktLast)
        else $error("byte position left the packet");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tsmp_pkg::PH_DATA |-> r_remaining != 8'd0)
        else $error("run data phase with no bytes left");

    a_not_both_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bus.load |-> !(o_bus.res.marked_valid && o_bus.res.payload_valid))
        else $error("byte flagged as both marked and payload");

    a_sync_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_sync_err && r_pos != 8'd0 |-> !marked && !payload)
        else $error("byte emitted from a packet with a bad sync byte");

endmodule

FILE: rtl/core/tsmp_out_stage.sv
`timescale 1ns / 1ps
// Result register of the parser, driving the valid/ready result channel.
// Depends on tsmp_pkg and tsmp_if.
module tsmp_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsmp_pkg::t_result_bus i_bus,
    output logic                  o_take,
    tsmp_out_if.source            o_out
);

    logic              r_valid;
    tsmp_pkg::t_result r_res;

    // A new result may land when the register is empty or is being emptied now.
    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_bus.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bus.load) begin
            r_res <= i_bus.res;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.marked_valid     = r_res.marked_valid;
    assign o_out.payload_valid    = r_res.payload_valid;
    assign o_out.out_byte         = r_res.out_byte;
    assign o_out.packet_end       = r_res.packet_end;
    assign o_out.packet_pid       = r_res.packet_pid;
    assign o_out.continuity       = r_res.continuity;
    assign o_out.has_adaptation   = r_res.has_adaptation;
    assign o_out.has_payload_flag = r_res.has_payload_flag;
    assign o_out.null_packet      = r_res.null_packet;
    assign o_out.stuffing_count   = r_res.stuffing_count;
    assign o_out.marked_length    = r_res.marked_length;
    assign o_out.sync_error       = r_res.sync_error;

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bus.load |-> o_take)
        else $error("result loaded over one not yet taken");

    a_result_means_something: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_res.marked_valid || r_res.payload_valid || r_res.packet_end)
        else $error("empty result presented");

    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_res.packet_end |-> r_res.packet_pid == 13'd0 && !r_res.sync_error
                                         && r_res.marked_length == 8'd0)
        else $error("packet summary outside the last byte");

endmodule

FILE: rtl/core/ts_packet_marked_data_parser_core.sv
`timescale 1ns / 1ps
// Top level of the transport stream packet parser with marked data run extraction.
// Depends on tsmp_pkg, tsmp_if, tsmp_apb, tsmp_decode and tsmp_out_stage.
//
// Usage:
//   i_in carries the transport stream, one byte per request, 188-byte packets back
//   to back with no gaps in the byte count. o_out carries at most one result per
//   byte: a marked run data byte, an ordinary payload byte of a non-null packet,
//   or the last byte of a packet with the packet summary (PID, continuity counter,
//   adaptation flags, stuffing count, last accepted run length, sync error).
//   Bytes that produce nothing are consumed silently.
//   The APB port holds the marker byte register at address 0; write it only while
//   the parser is idle.
// Timing:
//   Each byte is taken into an input register, decoded and written to the result
//   register, which drives o_out. One byte is accepted every cycle while the
//   receiver keeps taking results; the limit is the single decode step per byte
//   against the packet state.
// Reset and stalls:
//   Reset clears the packet position, so the first byte after reset is taken as
//   a sync byte, and sets the marker to zero. When the receiver stalls with a
//   result waiting, one more byte is held in the input register, after which
//   i_in.ready drops until the result is taken.
module ts_packet_marked_data_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tsmp_in_if.sink                        i_in,
    tsmp_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsmp_pkg::ApbAddrW-1:0]  paddr,
    input  logic [tsmp_pkg::ApbDataW-1:0]  pwdata,
    output logic [tsmp_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready
);

    logic [7:0]            marker;
    logic                  take;
    tsmp_pkg::t_result_bus bus;

    tsmp_apb u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_marker (marker)
    );

    tsmp_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_marker (marker),
        .i_take   (take),
        .o_bus    (bus)
    );

    tsmp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bus   (bus),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule
